@@ rtl/sgjp_pkg.sv @@
// Package for the sorted greedy job partition block.
// Fixed field widths and payload types. No dependencies.
package sgjp_pkg;
    localparam int TIME_W = 32;
    localparam int IDX_W  = 5;
    localparam int PROC_W = 4;
    localparam int CFG_W  = 5;
    localparam int FRAC_BITS = 10;

    typedef struct packed {
        logic [TIME_W-1:0] job_time;
        logic              last;
    } t_job_req;

    typedef struct packed {
        logic [IDX_W-1:0]  job_index;
        logic [PROC_W-1:0] processor;
        logic [TIME_W-1:0] duration;
        logic              end_of_batch;
    } t_assign_rsp;
endpackage

@@ rtl/sgjp_if.sv @@
// Valid/ready channel carrying one payload type.
// Depends on sgjp_pkg for payload types.
interface sgjp_job_if import sgjp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_job_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgjp_rsp_if import sgjp_pkg::*; ();
    logic        valid;
    logic        ready;
    t_assign_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgjp_cfg_if import sgjp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sorted_greedy_job_partition.sv @@
// Sorted greedy job partition, top level.
// Load: one job request per cycle into the time memory; no result for a non-last job.
// After last: insertion sort of the jobs (O(n^2) worst case), overlapped with a quota
// divide; then each assignment by an order read, a time read and an issue, issued
// while the output is free.
// Next batch accepted once the last assignment is issued. Sync active-low reset.
module sorted_greedy_job_partition
    import sgjp_pkg::*;
#(
    parameter int MAX_JOBS  = 32,
    parameter int MAX_PROCS = 16
) (
    input logic     i_clk,
    input logic     i_rst_n,
    sgjp_job_if.sink   s_job,
    sgjp_rsp_if.source m_rsp,
    sgjp_cfg_if.sink   s_cfg
);
    localparam int AW  = $clog2(MAX_JOBS);
    localparam int CW  = $clog2(MAX_JOBS + 1);
    localparam int PW  = $clog2(MAX_PROCS + 1);
    localparam int SW  = TIME_W + CW;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SINIT = 7'b0000010,
        S_SRD   = 7'b0000100,
        S_SCMP  = 7'b0001000,
        S_WDIV  = 7'b0010000,
        S_ORD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [TIME_W-1:0] r_time_mem [MAX_JOBS];
    logic [AW-1:0]     r_ord_mem  [MAX_JOBS];
    logic [CW-1:0] r_count, r_i, r_j, r_k;
    logic [SW-1:0] r_total, r_quota, r_run;
    logic [PW-1:0] r_procs, r_p;
    logic [CFG_W-1:0] r_cfg;
    logic [TIME_W-1:0] r_cur_t, r_rd_t, r_ord_t;
    logic [AW-1:0]     r_rd_o;
    logic r_div_done_seen, r_rd_pending;
    logic w_div_start, w_div_done;
    logic [SW-1:0] w_quot;
    logic w_before;
    logic w_emit;

    assign s_cfg.ready = 1'b1;
    assign s_job.ready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= CFG_W'(1);
        else if (s_cfg.valid) r_cfg <= s_cfg.data;
    end

    // current job (index r_i, time r_cur_t) goes before order entry r_j-1
    assign w_before = (r_cur_t > r_ord_t) ||
                      ((r_cur_t == r_ord_t) && (r_i < CW'(r_rd_o)));

    assign w_div_start = (r_state == S_LOAD) && s_job.valid && s_job.data.last;

    function automatic logic [SW-1:0] n_total_f();
        if (r_count < CW'(MAX_JOBS)) return r_total + SW'(s_job.data.job_time);
        else return r_total;
    endfunction

    function automatic logic [PW-1:0] n_procs_f();
        if (r_cfg == '0) return PW'(1);
        else if (32'(r_cfg) > MAX_PROCS) return PW'(MAX_PROCS);
        else return PW'(r_cfg);
    endfunction

    sgjp_div #(.N_W(SW), .D_W(PW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(n_total_f()), .i_den(n_procs_f()),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && s_job.valid && r_count < CW'(MAX_JOBS))
            r_time_mem[r_count[AW-1:0]] <= s_job.data.job_time;
    end

    logic [AW-1:0] w_trd_a, w_ord_a;
    always_comb begin
        w_trd_a = r_i[AW-1:0];
        w_ord_a = r_j[AW-1:0] - 1'b1;
        if (r_state == S_SCMP) begin
            w_trd_a = r_rd_o;
        end else if (r_state == S_ORD || r_state == S_OUT) begin
            w_ord_a = r_k[AW-1:0];
            w_trd_a = r_rd_o;
        end
    end
    always_ff @(posedge i_clk) begin
        r_rd_t <= r_time_mem[w_trd_a];
        r_rd_o <= r_ord_mem[w_ord_a];
    end
    assign r_ord_t = r_rd_t;

    logic r_out_v;
    t_assign_rsp r_out;
    assign m_rsp.valid = r_out_v;
    assign m_rsp.data  = r_out;

    // issue an assignment once its time word is in and the output is free
    assign w_emit = (r_state == S_OUT) && r_rd_pending && (!r_out_v || m_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_out_v <= 1'b0;
            r_div_done_seen <= 1'b0;
            r_rd_pending <= 1'b0;
        end else begin
            if (w_div_done) begin
                r_div_done_seen <= 1'b1;
                r_quota <= (w_quot >> FRAC_BITS) << FRAC_BITS;
            end
            if (w_emit) r_out_v <= 1'b1;
            else if (m_rsp.ready) r_out_v <= 1'b0;
            case (r_state)
                S_LOAD: if (s_job.valid) begin
                    if (r_count < CW'(MAX_JOBS)) begin
                        r_count <= r_count + 1'b1;
                        r_total <= r_total + SW'(s_job.data.job_time);
                    end
                    if (s_job.data.last) begin
                        r_procs <= n_procs_f();
                        r_div_done_seen <= 1'b0;
                        r_i <= '0;
                        r_state <= S_SINIT;
                    end
                end
                S_SINIT: begin
                    // r_i addresses time memory; data arrives next cycle
                    if (r_i == r_count) begin
                        r_state <= S_WDIV;
                    end else begin
                        r_j <= r_i;
                        r_rd_pending <= 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_rd_pending) begin
                        r_cur_t <= r_rd_t;
                        r_rd_pending <= 1'b0;
                    end
                    if (r_j == '0) begin
                        r_ord_mem[AW'(0)] <= r_i[AW-1:0];
                        r_i <= r_i + 1'b1;
                        r_state <= S_SINIT;
                    end else begin
                        // order entry r_j-1 read issued this cycle
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    // r_rd_o valid; time of it arrives next cycle, so compare once r_rd_pending is set
                    r_rd_pending <= ~r_rd_pending;
                    if (r_rd_pending) begin
                        if (w_before) begin
                            r_ord_mem[r_j[AW-1:0]] <= r_rd_o;
                            r_j <= r_j - 1'b1;
                            r_state <= S_SRD;
                        end else begin
                            r_ord_mem[r_j[AW-1:0]] <= r_i[AW-1:0];
                            r_i <= r_i + 1'b1;
                            r_state <= S_SINIT;
                        end
                    end
                end
                S_WDIV: if (r_div_done_seen || w_div_done) begin
                    r_k <= '0;
                    r_p <= '0;
                    r_run <= '0;
                    if (r_count == '0) begin
                        r_count <= '0;
                        r_total <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_ORD: r_state <= S_OUT; // order read at r_k issued
                S_OUT: if (!r_out_v || m_rsp.ready) begin
                    if (r_rd_pending) begin
                        r_rd_pending <= 1'b0;
                        r_out.job_index <= IDX_W'(r_rd_o);
                        r_out.duration  <= r_rd_t;
                        r_out.end_of_batch <= (r_k + 1'b1 == r_count);
                        if (r_run < r_quota && r_p < r_procs) begin
                            r_out.processor <= PROC_W'(r_p);
                            r_run <= r_run + SW'(r_rd_t);
                        end else if (r_p + 1'b1 < r_procs && r_quota != '0) begin
                            r_out.processor <= PROC_W'(r_p + 1'b1);
                            r_p <= r_p + 1'b1;
                            r_run <= SW'(r_rd_t);
                        end else begin
                            r_out.processor <= PROC_W'(r_procs - 1'b1);
                            r_p <= r_procs;
                        end
                        if (r_k + 1'b1 == r_count) begin
                            r_count <= '0;
                            r_total <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= S_ORD;
                        end
                    end else begin
                        r_rd_pending <= 1'b1; // time read at r_rd_o now issued
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

@@ rtl/sgjp_div.sv @@
// Restoring divider: wide dividend by small divisor, one quotient bit a cycle.
// Depends on nothing but its ports.
module sgjp_div #(
    parameter int N_W = 37,
    parameter int D_W = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quot
);
    localparam int CW = $clog2(N_W + 1);
    logic [N_W-1:0] r_q;
    logic [D_W:0]   r_rem;
    logic [D_W-1:0] r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [D_W:0]   w_try;

    assign w_try = {r_rem[D_W-1:0], r_q[N_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                r_rem <= w_try - {1'b0, r_den};
                r_q   <= {r_q[N_W-2:0], 1'b1};
            end else begin
                r_rem <= w_try;
                r_q   <= {r_q[N_W-2:0], 1'b0};
            end
        end
    end
    assign o_quot = r_q;
endmodule
